[rtl/tsaw_pkg.sv]
// tensor slice address walk: shared types, constants and the axis map
// used by the config, controller and datapath modules; no dependencies
`timescale 1ns / 1ps

package tsaw_pkg;

  localparam int DIM_BITS   = 16;
  localparam int INDEX_BITS = 32;
  localparam int MUL_W      = INDEX_BITS + DIM_BITS;
  localparam int REG_W      = 16;
  localparam int RANK_W     = 3;
  localparam int OUT_IDX_W  = 32;
  localparam int CFG_IDX_W  = 3;

  typedef logic [DIM_BITS-1:0]       dim_t;
  typedef logic [3:0][DIM_BITS-1:0]  dim4_t;
  typedef logic [INDEX_BITS-1:0]     idx_t;
  typedef logic [MUL_W-1:0]          mul_t;
  typedef logic [OUT_IDX_W-1:0]      out_idx_t;
  typedef logic [REG_W-1:0]          reg_t;
  typedef logic [RANK_W-1:0]         rank_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [1:0]                status_t;
  typedef logic [1:0]                axis_t;
  typedef logic [1:0]                step_t;

  // result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_AXIS  = 2'd1;
  localparam status_t ST_BAD_RANGE = 2'd2;
  localparam status_t ST_OVERFLOW  = 2'd3;

  // register indexes
  localparam cfg_idx_t REG_RANK        = 3'd0;
  localparam cfg_idx_t REG_AXIS        = 3'd1;
  localparam cfg_idx_t REG_OUTER       = 3'd2;
  localparam cfg_idx_t REG_CHANNELS    = 3'd3;
  localparam cfg_idx_t REG_HEIGHT      = 3'd4;
  localparam cfg_idx_t REG_WIDTH       = 3'd5;
  localparam cfg_idx_t REG_SLICE_START = 3'd6;
  localparam cfg_idx_t REG_SLICE_END   = 3'd7;

  // rank codes
  localparam rank_t RANK_CHW   = 3'd3;
  localparam rank_t RANK_BCHW  = 3'd4;
  localparam rank_t RANK_BTCHW = 3'd5;

  // multiply-accumulate steps over the channel, row and column digits
  localparam step_t STEP_LAST = 2'd2;

  // user axis to merged axis, per rank
  localparam axis_t AXIS_MAP3 [3] = '{2'd1, 2'd2, 2'd3};
  localparam axis_t AXIS_MAP4 [4] = '{2'd0, 2'd1, 2'd2, 2'd3};
  localparam axis_t AXIS_MAP5 [5] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd3};

  typedef struct packed {
    rank_t rank;
    rank_t axis;
    reg_t  outer;
    reg_t  channels;
    reg_t  height;
    reg_t  width;
    reg_t  slice_start;
    reg_t  slice_end;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  step;
    step_t step_idx;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    logic early_err;
  } stat_t;

  function automatic axis_t map_axis(input rank_t rank, input rank_t axis);
    axis_t m;
    m = 2'd0;
    unique case (rank)
      RANK_CHW:   if (axis < 3'd3) m = AXIS_MAP3[axis[1:0]];
      RANK_BCHW:  if (axis < 3'd4) m = AXIS_MAP4[axis[1:0]];
      RANK_BTCHW: if (axis < 3'd5) m = AXIS_MAP5[axis];
      default:    m = 2'd0;
    endcase
    return m;
  endfunction

endpackage

[rtl/tsaw_cfg.sv]
// tensor slice address walk: configuration register file
// depends on tsaw_pkg for the register indexes and the cfg_t struct
`timescale 1ns / 1ps

module tsaw_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  tsaw_pkg::cfg_idx_t cfg_index,
  input  tsaw_pkg::reg_t    cfg_wdata,
  output tsaw_pkg::cfg_t    cfg
);

  tsaw_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rank        <= 3'd4;
      cfg_r.axis        <= 3'd0;
      cfg_r.outer       <= 16'd1;
      cfg_r.channels    <= 16'd1;
      cfg_r.height      <= 16'd1;
      cfg_r.width       <= 16'd1;
      cfg_r.slice_start <= 16'd0;
      cfg_r.slice_end   <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsaw_pkg::REG_RANK:        cfg_r.rank        <= cfg_wdata[2:0];
        tsaw_pkg::REG_AXIS:        cfg_r.axis        <= cfg_wdata[2:0];
        tsaw_pkg::REG_OUTER:       cfg_r.outer       <= cfg_wdata;
        tsaw_pkg::REG_CHANNELS:    cfg_r.channels    <= cfg_wdata;
        tsaw_pkg::REG_HEIGHT:      cfg_r.height      <= cfg_wdata;
        tsaw_pkg::REG_WIDTH:       cfg_r.width       <= cfg_wdata;
        tsaw_pkg::REG_SLICE_START: cfg_r.slice_start <= cfg_wdata;
        tsaw_pkg::REG_SLICE_END:   cfg_r.slice_end   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/tsaw_ctrl.sv]
// tensor slice address walk: sequencing state machine
// depends on tsaw_pkg for the command and status structs
`timescale 1ns / 1ps

module tsaw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  tsaw_pkg::stat_t stat,
  output tsaw_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]      state_r, state_nxt;
  tsaw_pkg::step_t step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.step_idx = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          step_nxt  = 2'd0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        // a bad axis or range needs no index arithmetic
        if (stat.early_err) begin
          state_nxt = S_FIN;
        end else begin
          cmd.step = 1'b1;
          if (step_r == tsaw_pkg::STEP_LAST) begin
            state_nxt = S_FIN;
          end else begin
            step_nxt = step_r + 2'd1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

[rtl/tsaw_dp.sv]
// tensor slice address walk: shape checks, position walk and flat index
// multiply-accumulate lanes with the result register; depends on tsaw_pkg
`timescale 1ns / 1ps

module tsaw_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tsaw_pkg::cfg_t      cfg,
  input  logic                restart,
  input  tsaw_pkg::cmd_t      cmd,
  output tsaw_pkg::stat_t     stat,
  output tsaw_pkg::out_idx_t  out_src,
  output tsaw_pkg::out_idx_t  out_dst,
  output logic                out_last,
  output tsaw_pkg::status_t   out_status
);

  // walk position, held between items
  tsaw_pkg::dim4_t    pos_r;

  // per item working registers
  tsaw_pkg::dim4_t    dims_r, osh_r, dpos_r, spos_r, npos_r;
  logic               last_r;
  tsaw_pkg::status_t  code_r;
  tsaw_pkg::idx_t     acc_t_r, acc_d_r, acc_s_r;
  logic               ovf_r;

  // result register
  tsaw_pkg::out_idx_t res_src_r, res_dst_r;
  logic               res_last_r;
  tsaw_pkg::status_t  res_status_r;

  // setup, from configuration and held position
  tsaw_pkg::dim4_t    dims, osh, pos, ipos, npos;
  tsaw_pkg::dim_t     s, e, dsz;
  tsaw_pkg::axis_t    m;
  tsaw_pkg::status_t  code;
  logic               rank_ok, axis_err, range_err, outside, last;
  logic [3:0]         at_end;

  always_comb begin
    dims[0] = (cfg.rank == tsaw_pkg::RANK_CHW) ? tsaw_pkg::dim_t'(1)
                                               : tsaw_pkg::dim_t'(cfg.outer);
    dims[1] = tsaw_pkg::dim_t'(cfg.channels);
    dims[2] = tsaw_pkg::dim_t'(cfg.height);
    dims[3] = tsaw_pkg::dim_t'(cfg.width);
    s       = tsaw_pkg::dim_t'(cfg.slice_start);
    e       = tsaw_pkg::dim_t'(cfg.slice_end);
    m       = tsaw_pkg::map_axis(cfg.rank, cfg.axis);
    dsz     = dims[m];

    rank_ok   = (cfg.rank == tsaw_pkg::RANK_CHW) || (cfg.rank == tsaw_pkg::RANK_BCHW) ||
                (cfg.rank == tsaw_pkg::RANK_BTCHW);
    axis_err  = !rank_ok || (cfg.axis >= cfg.rank);
    range_err = (s >= dsz) || (e > dsz) || (e <= s) ||
                (dims[0] == '0) || (dims[1] == '0) || (dims[2] == '0) || (dims[3] == '0);
    if (axis_err) begin
      code = tsaw_pkg::ST_BAD_AXIS;
    end else if (range_err) begin
      code = tsaw_pkg::ST_BAD_RANGE;
    end else begin
      code = tsaw_pkg::ST_OK;
    end

    osh    = dims;
    osh[m] = e - s;

    outside = 1'b0;
    for (int d = 0; d < 4; d++) begin
      if (pos_r[d] >= osh[d]) outside = 1'b1;
    end
    pos = (restart || outside) ? '0 : pos_r;

    for (int d = 0; d < 4; d++) begin
      at_end[d] = (pos[d] == osh[d] - tsaw_pkg::dim_t'(1));
    end
    last = &at_end;

    // odometer step, column fastest; wraps to all zero after the last element
    npos[3] = at_end[3] ? '0 : pos[3] + tsaw_pkg::dim_t'(1);
    npos[2] = !at_end[3] ? pos[2] : (at_end[2] ? '0 : pos[2] + tsaw_pkg::dim_t'(1));
    npos[1] = !(at_end[3] && at_end[2]) ? pos[1] :
              (at_end[1] ? '0 : pos[1] + tsaw_pkg::dim_t'(1));
    npos[0] = !(at_end[3] && at_end[2] && at_end[1]) ? pos[0] :
              (at_end[0] ? '0 : pos[0] + tsaw_pkg::dim_t'(1));

    ipos    = pos;
    ipos[m] = s + pos[m];
  end

  // one multiply-accumulate per lane and step: digit step_idx + 1
  tsaw_pkg::axis_t dig;
  tsaw_pkg::mul_t  mt, md, ms, d0_ext;

  always_comb begin
    dig    = cmd.step_idx + 2'd1;
    mt     = tsaw_pkg::mul_t'(acc_t_r) * tsaw_pkg::mul_t'(dims_r[dig]);
    md     = tsaw_pkg::mul_t'(acc_d_r) * tsaw_pkg::mul_t'(osh_r[dig])
             + tsaw_pkg::mul_t'(dpos_r[dig]);
    ms     = tsaw_pkg::mul_t'(acc_s_r) * tsaw_pkg::mul_t'(dims_r[dig])
             + tsaw_pkg::mul_t'(spos_r[dig]);
    d0_ext = tsaw_pkg::mul_t'(dims[0]);
  end

  logic err_fin;
  assign err_fin = (code_r != tsaw_pkg::ST_OK) || ovf_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dims_r  <= dims;
      osh_r   <= osh;
      dpos_r  <= pos;
      spos_r  <= ipos;
      npos_r  <= npos;
      last_r  <= last;
      code_r  <= code;
      acc_t_r <= tsaw_pkg::idx_t'(dims[0]);
      acc_d_r <= tsaw_pkg::idx_t'(pos[0]);
      acc_s_r <= tsaw_pkg::idx_t'(ipos[0]);
      ovf_r   <= (d0_ext >> tsaw_pkg::INDEX_BITS) != '0;
    end else if (cmd.step) begin
      acc_t_r <= mt[tsaw_pkg::INDEX_BITS-1:0];
      acc_d_r <= md[tsaw_pkg::INDEX_BITS-1:0];
      acc_s_r <= ms[tsaw_pkg::INDEX_BITS-1:0];
      // dims are non-zero here, so once over the limit the product stays over
      if (mt[tsaw_pkg::MUL_W-1:tsaw_pkg::INDEX_BITS] != '0) ovf_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_src_r  <= err_fin ? '0 : tsaw_pkg::out_idx_t'(acc_s_r);
      res_dst_r  <= err_fin ? '0 : tsaw_pkg::out_idx_t'(acc_d_r);
      res_last_r <= err_fin ? 1'b0 : last_r;
      if (code_r != tsaw_pkg::ST_OK) begin
        res_status_r <= code_r;
      end else if (ovf_r) begin
        res_status_r <= tsaw_pkg::ST_OVERFLOW;
      end else begin
        res_status_r <= tsaw_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.finish) begin
      pos_r <= err_fin ? '0 : npos_r;
    end
  end

  assign stat.early_err = (code_r != tsaw_pkg::ST_OK);
  assign out_src        = res_src_r;
  assign out_dst        = res_dst_r;
  assign out_last       = res_last_r;
  assign out_status     = res_status_r;

endmodule

[rtl/tensor_slice_address_walk_top.sv]
// tensor slice address walk: top level, stream ports and assertions
// sequence: load, the three shared multiply-accumulate steps of the flat index chain in
// the datapath (skipped on a bad axis or range), then finish into the result register,
// which waits while an earlier result is not yet taken; one item is in flight at a time
// reset: synchronous active low rst_n; walk position cleared, registers to defaults
// depends on tsaw_pkg, tsaw_cfg, tsaw_ctrl and tsaw_dp
`timescale 1ns / 1ps

module tensor_slice_address_walk_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] restart, [7:1] zero
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // [31:0] src_index, [63:32] dst_index
  output logic                 out_tlast,
  output logic [1:0]           out_tuser,  // [1:0] status
  input  logic                 cfg_we,
  input  tsaw_pkg::cfg_idx_t   cfg_index,
  input  tsaw_pkg::reg_t       cfg_wdata
);

  tsaw_pkg::cfg_t     cfg;
  tsaw_pkg::cmd_t     cmd;
  tsaw_pkg::stat_t    stat;
  tsaw_pkg::out_idx_t src, dst;
  tsaw_pkg::status_t  status;
  logic               last;

  tsaw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tsaw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tsaw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .restart    (in_tdata[0]),
    .cmd        (cmd),
    .stat       (stat),
    .out_src    (src),
    .out_dst    (dst),
    .out_last   (last),
    .out_status (status)
  );

  assign out_tdata = {dst, src};
  assign out_tlast = last;
  assign out_tuser = status;

  // one item in flight: no new transfer straight after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in flight");

  // error results carry zero indexes and no last marker
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != tsaw_pkg::ST_OK)) |-> ((out_tdata == '0) && !out_tlast))
    else $error("error result with non-zero payload");

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("block not empty after reset");

endmodule

[tb/tb_tensor_slice_address_walk_top.sv]
// testbench for tensor_slice_address_walk_top: directed and random address walks
// checked against an in-bench scoreboard that tracks registers and walk position
// depends on tsaw_pkg and the rtl of tensor_slice_address_walk_top
`timescale 1ns / 1ps

module tb_tensor_slice_address_walk_top;
  import tsaw_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1450;

  typedef struct packed {
    out_idx_t src;
    out_idx_t dst;
    logic     last;
    status_t  status;
  } addr_pair_t;

  class slice_walk_scoreboard;
    rank_t      rank_q;
    rank_t      axis_q;
    reg_t       outer_q;
    reg_t       chan_q;
    reg_t       rows_q;
    reg_t       cols_q;
    reg_t       start_q;
    reg_t       stop_q;
    dim_t       pos_q [4];
    addr_pair_t pending [$];
    int         fail_count;

    function new();
      fail_count = 0;
      reset_model();
    endfunction

    function void clear_walk();
      foreach (pos_q[d]) pos_q[d] = '0;
    endfunction

    function void reset_model();
      rank_q  = RANK_BCHW;
      axis_q  = '0;
      outer_q = 1;
      chan_q  = 1;
      rows_q  = 1;
      cols_q  = 1;
      start_q = 0;
      stop_q  = 1;
      clear_walk();
    endfunction

    function void write_reg(cfg_idx_t idx, reg_t data);
      case (idx)
        REG_RANK:        rank_q  = data[RANK_W-1:0];
        REG_AXIS:        axis_q  = data[RANK_W-1:0];
        REG_OUTER:       outer_q = data;
        REG_CHANNELS:    chan_q  = data;
        REG_HEIGHT:      rows_q  = data;
        REG_WIDTH:       cols_q  = data;
        REG_SLICE_START: start_q = data;
        default:         stop_q  = data;
      endcase
    endfunction

    // batch and time both land on the outer axis for rank 5
    function int fold_axis(rank_t r, rank_t a);
      case (r)
        RANK_CHW:  return int'(a) + 1;
        RANK_BCHW: return int'(a);
        default:   return (a == 0) ? 0 : int'(a) - 1;
      endcase
    endfunction

    function void push_error(status_t code);
      addr_pair_t r;
      r = '0;
      r.status = code;
      pending.push_back(r);
      clear_walk();
    endfunction

    function void note_input(logic restart);
      logic [63:0] dims [4];
      logic [63:0] osh [4];
      logic [63:0] pos [4];
      logic [63:0] ipos [4];
      logic [63:0] total, s, e, src_f, dst_f;
      int          m;
      logic        at_last, outside, carry;
      addr_pair_t  r;
      if (rank_q < RANK_CHW || rank_q > RANK_BTCHW || axis_q >= rank_q) begin
        push_error(ST_BAD_AXIS);
        return;
      end
      m = fold_axis(rank_q, axis_q);
      dims[0] = (rank_q == RANK_CHW) ? 64'd1 : 64'(outer_q);
      dims[1] = 64'(chan_q);
      dims[2] = 64'(rows_q);
      dims[3] = 64'(cols_q);
      s = 64'(start_q);
      e = 64'(stop_q);
      if (s >= dims[m] || e > dims[m] || e <= s ||
          dims[0] == 0 || dims[1] == 0 || dims[2] == 0 || dims[3] == 0) begin
        push_error(ST_BAD_RANGE);
        return;
      end
      total = dims[0] * dims[1] * dims[2] * dims[3];
      if (total >= 64'h1_0000_0000) begin
        push_error(ST_OVERFLOW);
        return;
      end
      outside = 1'b0;
      at_last = 1'b1;
      for (int d = 0; d < 4; d++) begin
        osh[d] = dims[d];
      end
      osh[m] = e - s;
      for (int d = 0; d < 4; d++) begin
        pos[d] = 64'(pos_q[d]);
        if (pos[d] >= osh[d]) outside = 1'b1;
      end
      // a shape change that leaves the held position outside restarts the pass
      if (restart || outside) begin
        for (int d = 0; d < 4; d++) pos[d] = 0;
      end
      src_f = 0;
      dst_f = 0;
      for (int d = 0; d < 4; d++) begin
        ipos[d] = (d == m) ? s + pos[d] : pos[d];
        if (pos[d] != osh[d] - 1) at_last = 1'b0;
        dst_f = dst_f * osh[d] + pos[d];
        src_f = src_f * dims[d] + ipos[d];
      end
      carry = !at_last;
      for (int d = 3; d >= 0; d--) begin
        if (at_last) begin
          pos[d] = 0;
        end else if (carry) begin
          pos[d] = pos[d] + 1;
          if (pos[d] < osh[d]) carry = 1'b0;
          else pos[d] = 0;
        end
      end
      for (int d = 0; d < 4; d++) pos_q[d] = pos[d][DIM_BITS-1:0];
      r.src    = src_f[31:0];
      r.dst    = dst_f[31:0];
      r.last   = at_last;
      r.status = ST_OK;
      pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] data, logic tlast, status_t tuser);
      addr_pair_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result src %h dst %h last %b status %0d",
                 $time, data[31:0], data[63:32], tlast, tuser);
        fail_count++;
        return;
      end
      want = pending.pop_front();
      if (data[31:0] !== want.src) begin
        $display("%0t: src_index expected %h actual %h", $time, want.src, data[31:0]);
        fail_count++;
      end
      if (data[63:32] !== want.dst) begin
        $display("%0t: dst_index expected %h actual %h", $time, want.dst, data[63:32]);
        fail_count++;
      end
      if (tlast !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, tlast);
        fail_count++;
      end
      if (tuser !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, tuser);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] restart, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [31:0] src_index, [63:32] dst_index
  logic        out_tlast;
  logic [1:0]  out_tuser;  // [1:0] status
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  reg_t        cfg_wdata;

  slice_walk_scoreboard sb;
  int   cycle_count = 0;
  int   items_sent;
  logic idle_on;

  tensor_slice_address_walk_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_tensor_slice_address_walk_top NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= !idle_on || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // registers only change while the walk is idle
  task automatic load_config(input reg_t vals [8], input logic [7:0] mask);
    reg_t data;
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        data = vals[i];
        if (i == REG_RANK || i == REG_AXIS) begin
          data[REG_W-1:RANK_W] = (REG_W-RANK_W)'($urandom());
        end
        cfg_we    <= 1'b1;
        cfg_index <= cfg_idx_t'(i);
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(cfg_idx_t'(i), data);
        @(negedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic full_config(input rank_t r, input rank_t a, input reg_t o, input reg_t c,
                             input reg_t h, input reg_t w, input reg_t s, input reg_t e);
    reg_t vals [8];
    vals = '{reg_t'(r), reg_t'(a), o, c, h, w, s, e};
    load_config(vals, 8'hFF);
  endtask

  task automatic write_one(input cfg_idx_t idx, input reg_t data);
    reg_t vals [8];
    foreach (vals[i]) vals[i] = '0;
    vals[idx] = data;
    load_config(vals, 8'd1 << idx);
  endtask

  task automatic send_burst(input int count, input int restart_pct);
    logic restart;
    for (int k = 0; k < count; k++) begin
      restart = ($urandom_range(0, 99) < restart_pct);
      if (idle_on && $urandom_range(0, 99) < 11) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {7'b0, restart};
      do @(posedge clk); while (!in_tready);
      sb.note_input(restart);
      items_sent++;
      @(negedge clk);
    end
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase();
    int          kind, m, hi, s, e;
    rank_t       r, a;
    reg_t        vals [8];
    reg_t        pool [5];
    logic [7:0]  mask;
    kind = $urandom_range(0, 99);
    mask = 8'hFF;
    if (kind < 70 || kind >= 90) begin
      // well-formed shape, mostly small so passes run to their end
      r = rank_t'($urandom_range(3, 5));
      a = rank_t'($urandom_range(0, r - 1));
      m = sb.fold_axis(r, a);
      vals[0] = reg_t'(r);
      vals[1] = reg_t'(a);
      vals[2] = (r == RANK_CHW) ? reg_t'($urandom()) : reg_t'($urandom_range(1, 3));
      for (int d = 3; d < 6; d++) vals[d] = reg_t'($urandom_range(1, 4));
      if (kind >= 90) begin
        vals[m + 2] = $urandom_range(0, 1) ? 16'hFFFF : reg_t'($urandom_range(1000, 65535));
      end
      hi = (m == 0 && r == RANK_CHW) ? 1 : int'(vals[m + 2]);
      s  = $urandom_range(0, hi - 1);
      e  = (kind >= 90) ? s + 1 + $urandom_range(0, (hi - s - 1 < 20) ? hi - s - 1 : 20)
                        : $urandom_range(s + 1, hi);
      vals[6] = reg_t'(s);
      vals[7] = reg_t'(e);
    end else if (kind < 80) begin
      // nudge one or two registers while a pass may be under way
      foreach (vals[i]) vals[i] = reg_t'($urandom_range(0, 5));
      vals[REG_RANK] = reg_t'($urandom_range(2, 6));
      mask = (8'd1 << $urandom_range(0, 7)) | (8'd1 << $urandom_range(0, 7));
    end else begin
      pool = '{16'd0, 16'd1, 16'd2, 16'hFFFF, reg_t'($urandom())};
      foreach (vals[i]) vals[i] = pool[$urandom_range(0, 4)];
      vals[REG_RANK] = reg_t'($urandom_range(0, 7));
      vals[REG_AXIS] = reg_t'($urandom_range(0, 7));
    end
    load_config(vals, mask);
    send_burst($urandom_range(8, 60), 4);
  endtask

  initial begin
    int target;
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_RANK;
    cfg_wdata  = '0;
    idle_on    = 1'b1;
    items_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // advance straight after reset, then wrap after the single-element pass
    send_burst(2, 0);
    send_burst(1, 100);

    // rank 3 channel slice, then a height change that strands the position
    full_config(RANK_CHW, 3'd0, 16'd7, 16'd2, 16'd3, 16'd4, 16'd1, 16'd2);
    send_burst(4, 0);
    write_one(REG_HEIGHT, 16'd1);
    send_burst(1, 0);

    // ranks out of range
    write_one(REG_RANK, 16'hFFFA);
    send_burst(1, 0);
    write_one(REG_RANK, 16'd7);
    send_burst(1, 0);
    write_one(REG_RANK, 16'd0);
    send_burst(1, 0);

    // last user axis of rank 5, then one past it
    full_config(RANK_BTCHW, 3'd4, 16'd6, 16'd2, 16'd2, 16'd3, 16'd1, 16'd3);
    send_burst(2, 0);
    write_one(REG_AXIS, 16'd5);
    send_burst(1, 0);

    // bad ranges: start past the axis, end past the axis, empty, zero dimension
    full_config(RANK_BCHW, 3'd1, 16'd2, 16'd3, 16'd2, 16'd2, 16'd3, 16'd3);
    send_burst(1, 0);
    write_one(REG_SLICE_START, 16'd0);
    write_one(REG_SLICE_END, 16'd4);
    send_burst(1, 0);
    write_one(REG_SLICE_END, 16'd0);
    send_burst(1, 0);
    full_config(RANK_BCHW, 3'd0, 16'd2, 16'd0, 16'd2, 16'd2, 16'd0, 16'd1);
    send_burst(1, 0);

    // element count right at the index limit, then just under it
    full_config(RANK_BCHW, 3'd0, 16'd256, 16'd256, 16'd256, 16'd256, 16'd0, 16'd256);
    send_burst(1, 0);
    write_one(REG_OUTER, 16'd255);
    write_one(REG_SLICE_START, 16'd254);
    write_one(REG_SLICE_END, 16'd255);
    send_burst(2, 0);

    // widest column on rank 3 with outer ignored, then all dimensions at maximum
    full_config(RANK_CHW, 3'd2, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 16'hFFFE, 16'hFFFF);
    send_burst(1, 0);
    full_config(RANK_CHW, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    send_burst(1, 0);

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      idle_on = !(items_sent > target - 950 && items_sent < target - 600);
      random_phase();
    end

    idle_on = 1'b1;
    wait_drained();
    if (sb.fail_count == 0) begin
      $display("tb_tensor_slice_address_walk_top OK");
    end else begin
      $display("tb_tensor_slice_address_walk_top NOT OK");
    end
    $finish;
  end

endmodule
